// ===== rtl/core/fiv_pkg.sv =====
// fiv_pkg: shared types, constants and the crc32 byte step for the
// firmware image verifier; used by every module under rtl/core
`default_nettype none

package fiv_pkg;

    // image size cap and crc constants
    localparam int unsigned MAX_IMAGE_BYTES = 262144;
    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
    localparam logic [7:0]  PAD_BYTE        = 8'hFF;
    localparam logic [3:0]  HDR_LAST_IDX    = 4'd15;

    // configuration register indexes and reset values
    localparam logic        CFG_LENGTH_LIMIT   = 1'b0;
    localparam logic        CFG_EXPECTED_MAGIC = 1'b1;
    localparam logic [18:0] LIMIT_RESET        = 19'd262144;
    localparam logic [31:0] MAGIC_RESET        = 32'h4F54_4146;

    // result kinds
    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // verdict status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd2;
    localparam logic [2:0] ST_SHORT      = 3'd3;
    localparam logic [2:0] ST_CRC_FAIL   = 3'd4;

    // header word selects
    localparam logic [1:0] HW_MAGIC   = 2'd0;
    localparam logic [1:0] HW_VERSION = 2'd1;
    localparam logic [1:0] HW_LENGTH  = 2'd2;
    localparam logic [1:0] HW_CRC     = 2'd3;

    // job queue sizing
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // parser phase
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_DONE
    } phase_t;

    // one job from the parser: an optional flash write then an optional verdict
    typedef struct packed {
        logic        wr_valid;
        logic [17:0] wr_offset;
        logic [15:0] wr_halfword;
        logic        vd_valid;
        logic [2:0]  vd_status;
        logic [31:0] vd_version;
    } job_t;

    // reflected crc32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] c_in,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fiv_front.sv =====
// fiv_front: accepts image bytes, holds configuration, parses the header,
// runs the crc and builds write/verdict jobs; depends on fiv_pkg
`default_nettype none

module fiv_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic [7:0]    data_byte,
    input  wire logic          start_of_image,
    input  wire logic          end_of_file,
    input  wire logic          cfg_fire,
    input  wire logic          cfg_index,
    input  wire logic [31:0]   cfg_data,
    output logic               job_push,
    output fiv_pkg::job_t      job
);

    logic [18:0]     limit_reg;
    logic [31:0]     magic_cfg_reg;

    fiv_pkg::phase_t phase_reg, phase_next;
    logic [18:0]     count_reg, count_next;
    logic [31:0]     magic_reg, magic_next;
    logic [31:0]     version_reg, version_next;
    logic [31:0]     length_reg, length_next;
    logic [31:0]     crc_reg, crc_next;
    logic [31:0]     run_reg, run_next;
    logic [7:0]      pending_reg, pending_next;

    // state as seen after an optional restart
    fiv_pkg::phase_t cur_phase;
    logic [18:0]     cur_count;
    logic [31:0]     cur_magic, cur_version, cur_length, cur_crc, cur_run;
    logic [7:0]      cur_pending;

    logic [3:0]      hdr_idx;
    logic [31:0]     lane_val;
    logic [31:0]     lim;
    logic            hdr_done, hdr_bad_magic, hdr_bad_len;
    logic [31:0]     crc_after;
    logic            final_byte;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= fiv_pkg::LIMIT_RESET;
            magic_cfg_reg <= fiv_pkg::MAGIC_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                fiv_pkg::CFG_LENGTH_LIMIT:   limit_reg     <= cfg_data[18:0];
                fiv_pkg::CFG_EXPECTED_MAGIC: magic_cfg_reg <= cfg_data;
                default:                     limit_reg     <= limit_reg;
            endcase
        end
    end

    // restart view and header byte placement
    always_comb
    begin
        cur_phase   = start_of_image ? fiv_pkg::PH_HEADER : phase_reg;
        cur_count   = start_of_image ? 19'd0 : count_reg;
        cur_magic   = start_of_image ? 32'd0 : magic_reg;
        cur_version = start_of_image ? 32'd0 : version_reg;
        cur_length  = start_of_image ? 32'd0 : length_reg;
        cur_crc     = start_of_image ? 32'd0 : crc_reg;
        cur_run     = start_of_image ? fiv_pkg::ALL_ONES : run_reg;
        cur_pending = start_of_image ? 8'd0 : pending_reg;

        hdr_idx  = cur_count[3:0];
        lane_val = {24'd0, data_byte} << {hdr_idx[1:0], 3'b000};

        magic_next   = cur_magic;
        version_next = cur_version;
        length_next  = cur_length;
        crc_next     = cur_crc;
        if (cur_phase == fiv_pkg::PH_HEADER)
        begin
            case (hdr_idx[3:2])
                fiv_pkg::HW_MAGIC:   magic_next   = cur_magic | lane_val;
                fiv_pkg::HW_VERSION: version_next = cur_version | lane_val;
                fiv_pkg::HW_LENGTH:  length_next  = cur_length | lane_val;
                default:             crc_next     = cur_crc | lane_val;
            endcase
        end

        // header checks on the completed words
        lim = (32'(limit_reg) < 32'(fiv_pkg::MAX_IMAGE_BYTES))
              ? 32'(limit_reg) : 32'(fiv_pkg::MAX_IMAGE_BYTES);
        hdr_done      = (hdr_idx == fiv_pkg::HDR_LAST_IDX);
        hdr_bad_magic = (magic_next != magic_cfg_reg);
        hdr_bad_len   = (length_next == 32'd0) || (length_next > lim);

        // data byte crc and end test
        crc_after  = fiv_pkg::crc32_byte(cur_run, data_byte);
        final_byte = ((32'(cur_count) + 32'd1) >= cur_length);
    end

    // next state
    always_comb
    begin
        phase_next   = cur_phase;
        count_next   = cur_count;
        run_next     = cur_run;
        pending_next = cur_pending;
        case (cur_phase)
            fiv_pkg::PH_HEADER:
            begin
                count_next = cur_count + 19'd1;
                if (!hdr_done)
                begin
                    if (end_of_file)
                    begin
                        phase_next = fiv_pkg::PH_DONE;
                    end
                end
                else if (hdr_bad_magic || hdr_bad_len || end_of_file)
                begin
                    phase_next = fiv_pkg::PH_DONE;
                end
                else
                begin
                    phase_next = fiv_pkg::PH_DATA;
                    count_next = 19'd0;
                end
            end
            fiv_pkg::PH_DATA:
            begin
                run_next   = crc_after;
                count_next = cur_count + 19'd1;
                if (!cur_count[0])
                begin
                    pending_next = data_byte;
                end
                if (final_byte || end_of_file)
                begin
                    phase_next = fiv_pkg::PH_DONE;
                end
            end
            default:
            begin
                phase_next = cur_phase;
            end
        endcase
    end

    // job outputs
    always_comb
    begin
        job = '0;
        case (cur_phase)
            fiv_pkg::PH_HEADER:
            begin
                if (!hdr_done)
                begin
                    if (end_of_file)
                    begin
                        job.vd_valid  = 1'b1;
                        job.vd_status = fiv_pkg::ST_SHORT;
                    end
                end
                else if (hdr_bad_magic)
                begin
                    job.vd_valid   = 1'b1;
                    job.vd_status  = fiv_pkg::ST_BAD_MAGIC;
                    job.vd_version = version_next;
                end
                else if (hdr_bad_len)
                begin
                    job.vd_valid   = 1'b1;
                    job.vd_status  = fiv_pkg::ST_BAD_LENGTH;
                    job.vd_version = version_next;
                end
                else if (end_of_file)
                begin
                    job.vd_valid   = 1'b1;
                    job.vd_status  = fiv_pkg::ST_SHORT;
                    job.vd_version = version_next;
                end
            end
            fiv_pkg::PH_DATA:
            begin
                if (cur_count[0])
                begin
                    job.wr_valid    = 1'b1;
                    job.wr_offset   = {cur_count[17:1], 1'b0};
                    job.wr_halfword = {data_byte, cur_pending};
                end
                else if (final_byte || end_of_file)
                begin
                    job.wr_valid    = 1'b1;
                    job.wr_offset   = cur_count[17:0];
                    job.wr_halfword = {fiv_pkg::PAD_BYTE, data_byte};
                end
                if (final_byte)
                begin
                    job.vd_valid   = 1'b1;
                    job.vd_status  = ((crc_after ^ fiv_pkg::ALL_ONES) == cur_crc)
                                     ? fiv_pkg::ST_OK : fiv_pkg::ST_CRC_FAIL;
                    job.vd_version = cur_version;
                end
                else if (end_of_file)
                begin
                    job.vd_valid   = 1'b1;
                    job.vd_status  = fiv_pkg::ST_SHORT;
                    job.vd_version = cur_version;
                end
            end
            default:
            begin
                job = '0;
            end
        endcase
        job_push = in_fire && (job.wr_valid || job.vd_valid);
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= fiv_pkg::PH_HEADER;
            count_reg   <= 19'd0;
            magic_reg   <= 32'd0;
            version_reg <= 32'd0;
            length_reg  <= 32'd0;
            crc_reg     <= 32'd0;
            run_reg     <= fiv_pkg::ALL_ONES;
            pending_reg <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            magic_reg   <= magic_next;
            version_reg <= version_next;
            length_reg  <= length_next;
            crc_reg     <= crc_next;
            run_reg     <= run_next;
            pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fiv_queue.sv =====
// fiv_queue: short job queue between parser and result emitter
// depends on fiv_pkg for the job type and depth
`default_nettype none

module fiv_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire fiv_pkg::job_t  push_job,
    input  wire logic           pop,
    output logic                full,
    output logic                empty,
    output fiv_pkg::job_t       head_job
);

    fiv_pkg::job_t                entries [fiv_pkg::QUEUE_DEPTH];
    logic [fiv_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [fiv_pkg::QCNT_W-1:0]   count_reg, count_next;

    // status
    assign full     = (count_reg == (fiv_pkg::QCNT_W)'(fiv_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = entries[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    // fill count
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (fiv_pkg::QCNT_W)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (fiv_pkg::QCNT_W)'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + (fiv_pkg::QPTR_W)'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + (fiv_pkg::QPTR_W)'(1);
            end
            count_reg <= count_next;
        end
    end

    // no overrun, no underrun
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("job queue pushed while full");
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job queue popped while empty");

endmodule

`default_nettype wire

// ===== rtl/core/fiv_back.sv =====
// fiv_back: pops jobs and emits results through an output register,
// write before verdict; depends on fiv_pkg
`default_nettype none

module fiv_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire fiv_pkg::job_t  head_job,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic                kind,
    output logic [17:0]         write_offset,
    output logic [15:0]         halfword,
    output logic [2:0]          status,
    output logic [31:0]         image_version,
    output logic                last
);

    logic        out_valid_reg, out_valid_next;
    logic        hold_reg, hold_next;
    logic [2:0]  hold_status_reg, hold_status_next;
    logic [31:0] hold_version_reg, hold_version_next;
    logic        kind_reg, kind_next;
    logic [17:0] offset_reg, offset_next;
    logic [15:0] half_reg, half_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] version_reg, version_next;
    logic        last_reg, last_next;
    logic        slot_free;

    // output slot loading
    always_comb
    begin
        slot_free         = !out_valid_reg || out_ready;
        pop               = slot_free && !hold_reg && !q_empty;
        out_valid_next    = out_valid_reg && !out_ready;
        hold_next         = hold_reg;
        hold_status_next  = hold_status_reg;
        hold_version_next = hold_version_reg;
        kind_next         = kind_reg;
        offset_next       = offset_reg;
        half_next         = half_reg;
        status_next       = status_reg;
        version_next      = version_reg;
        last_next         = last_reg;
        if (slot_free && hold_reg)
        begin
            out_valid_next = 1'b1;
            hold_next      = 1'b0;
            kind_next      = fiv_pkg::KIND_VERDICT;
            offset_next    = 18'd0;
            half_next      = 16'd0;
            status_next    = hold_status_reg;
            version_next   = hold_version_reg;
            last_next      = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b1;
            if (head_job.wr_valid)
            begin
                kind_next         = fiv_pkg::KIND_WRITE;
                offset_next       = head_job.wr_offset;
                half_next         = head_job.wr_halfword;
                status_next       = fiv_pkg::ST_OK;
                version_next      = 32'd0;
                last_next         = !head_job.vd_valid;
                hold_next         = head_job.vd_valid;
                hold_status_next  = head_job.vd_status;
                hold_version_next = head_job.vd_version;
            end
            else
            begin
                kind_next    = fiv_pkg::KIND_VERDICT;
                offset_next  = 18'd0;
                half_next    = 16'd0;
                status_next  = head_job.vd_status;
                version_next = head_job.vd_version;
                last_next    = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hold_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            hold_reg      <= hold_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_status_reg  <= hold_status_next;
        hold_version_reg <= hold_version_next;
        kind_reg         <= kind_next;
        offset_reg       <= offset_next;
        half_reg         <= half_next;
        status_reg       <= status_next;
        version_reg      <= version_next;
        last_reg         <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign write_offset  = offset_reg;
    assign halfword      = half_reg;
    assign status        = status_reg;
    assign image_version = version_reg;
    assign last          = last_reg;

    // a held verdict always sits behind a write on the output
    a_hold_behind_write: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg |-> (out_valid_reg && kind_reg == fiv_pkg::KIND_WRITE && !last_reg))
        else $error("held verdict without its write on the output");
    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == fiv_pkg::KIND_VERDICT) |-> last_reg)
        else $error("verdict not marked last");

endmodule

`default_nettype wire

// ===== rtl/core/firmware_image_verifier_unit.sv =====
// firmware_image_verifier_unit: top level joining parser, job queue and
// result emitter; depends on fiv_pkg, fiv_front, fiv_queue, fiv_back
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    data_byte, start_of_image, end_of_file
//  out      output     out_valid / out_ready  kind, write_offset, halfword, status,
//                                             image_version, last
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one byte is accepted per cycle while the job queue is not full; the header parse
// and a one-byte crc32 step are done in the cycle the byte is taken
// a data byte that ends the image yields a write and then a verdict on the output;
// the four-entry job queue absorbs that and any output stall
// in_ready drops only when the job queue is full; cfg_ready is always high
// reset clears the parser to the header phase and loads register defaults
`default_nettype none

module firmware_image_verifier_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_of_image,
    input  wire logic        end_of_file,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [17:0]      write_offset,
    output logic [15:0]      halfword,
    output logic [2:0]       status,
    output logic [31:0]      image_version,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic          q_full, q_empty, q_pop, job_push;
    fiv_pkg::job_t job, head_job;
    logic          in_fire;

    assign in_ready  = !q_full;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // parser
    fiv_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (in_fire),
        .data_byte      (data_byte),
        .start_of_image (start_of_image),
        .end_of_file    (end_of_file),
        .cfg_fire       (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .job_push       (job_push),
        .job            (job)
    );

    // job queue
    fiv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_job (head_job)
    );

    // result emitter
    fiv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .head_job      (head_job),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .write_offset  (write_offset),
        .halfword      (halfword),
        .status        (status),
        .image_version (image_version),
        .last          (last)
    );

endmodule

`default_nettype wire

// ===== dv/firmware_image_verifier_unit_test.sv =====
// firmware_image_verifier_unit_test: self-checking bench for the firmware image verifier
// drives header, data and noise byte streams with random gaps and stalls and checks every
// flash write and verdict against an in-bench parser; depends on fiv_pkg and the top level
`timescale 1ns / 100ps

module firmware_image_verifier_unit_test;

    localparam int TIMEOUT_NS      = 4_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 135;

    // one flash write or verdict as seen on the output channel
    typedef struct packed {
        logic        kind;
        logic [17:0] write_offset;
        logic [15:0] halfword;
        logic [2:0]  status;
        logic [31:0] image_version;
        logic        last;
    } flash_op_t;

    // one directed item, with an optional typed-in verdict
    typedef struct packed {
        logic [7:0]  data;
        logic        sop;
        logic        eof;
        logic        pinned;
        logic [2:0]  status;
        logic [31:0] version;
    } stim_row_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_LENGTH,
        FLAW_EOF_HDR,
        FLAW_EOF_DATA,
        FLAW_CRC,
        FLAW_NOISE
    } flaw_t;

    // reset-time image: header without a start mark, three data bytes, then short files
    localparam stim_row_t DIRECTED_ROWS [0:22] = '{
        '{8'h46, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'h41, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'h54, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'h4F, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'h78, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'h56, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'h34, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'h12, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'h03, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'hA5, 1'b0, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'h00, 1'b0, 1'b1, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'hFF, 1'b1, 1'b1, 1'b1, fiv_pkg::ST_SHORT, 32'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, fiv_pkg::ST_OK, 32'h0},
        '{8'h7F, 1'b0, 1'b1, 1'b1, fiv_pkg::ST_SHORT, 32'h0}
    };

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte      = 8'h00;
    logic        start_of_image = 1'b0;
    logic        end_of_file    = 1'b0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic        kind;
    logic [17:0] write_offset;
    logic [15:0] halfword;
    logic [2:0]  status;
    logic [31:0] image_version;
    logic        last;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic        cfg_index      = 1'b0;
    logic [31:0] cfg_data       = 32'h0;

    // parser copy: registers and per-image state
    logic [18:0]     lim_reg;
    logic [31:0]     magic_reg;
    fiv_pkg::phase_t ph;
    logic [18:0]     cnt;
    logic [31:0]     h_magic;
    logic [31:0]     h_version;
    logic [31:0]     h_length;
    logic [31:0]     h_crc;
    logic [31:0]     crc_acc;
    logic [7:0]      pend;

    flash_op_t   step_ops [0:1];
    int          step_n;
    flash_op_t   flash_ops_due [$];
    int          errors     = 0;
    int          items_done = 0;
    logic        burst      = 1'b0;

    firmware_image_verifier_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .start_of_image (start_of_image),
        .end_of_file    (end_of_file),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .write_offset   (write_offset),
        .halfword       (halfword),
        .status         (status),
        .image_version  (image_version),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #TIMEOUT_NS;
        $display("[FAIL] regression broken");
        $finish;
    end

    // reflected crc32 over one byte, bit-serial
    function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (fiv_pkg::CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [31:0] effective_limit();
        return (lim_reg < fiv_pkg::MAX_IMAGE_BYTES)
               ? {13'd0, lim_reg} : 32'(fiv_pkg::MAX_IMAGE_BYTES);
    endfunction

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic void clear_parse();
        ph        = fiv_pkg::PH_HEADER;
        cnt       = 19'd0;
        h_magic   = 32'h0;
        h_version = 32'h0;
        h_length  = 32'h0;
        h_crc     = 32'h0;
        crc_acc   = fiv_pkg::ALL_ONES;
        pend      = 8'h00;
    endfunction

    function automatic void emit(input logic k, input logic [17:0] off, input logic [15:0] hw,
                                 input logic [2:0] st, input logic [31:0] ver);
        step_ops[step_n] = '{k, off, hw, st, ver, 1'b0};
        step_n++;
    endfunction

    // advance the parser copy by one byte; results land in step_ops
    function automatic void parse_image_byte(input logic [7:0] b, input logic sop,
                                             input logic eof);
        logic [3:0]  idx;
        logic [31:0] shifted;
        logic        final_byte;
        step_n = 0;
        if (sop)
        begin
            clear_parse();
        end
        if (ph == fiv_pkg::PH_HEADER)
        begin
            // little-endian header word assembly
            idx     = cnt[3:0];
            shifted = {24'd0, b} << (8 * idx[1:0]);
            case (idx[3:2])
                fiv_pkg::HW_MAGIC:   h_magic   = h_magic | shifted;
                fiv_pkg::HW_VERSION: h_version = h_version | shifted;
                fiv_pkg::HW_LENGTH:  h_length  = h_length | shifted;
                default:             h_crc     = h_crc | shifted;
            endcase
            cnt = cnt + 19'd1;
            if (idx != fiv_pkg::HDR_LAST_IDX)
            begin
                if (eof)
                begin
                    emit(fiv_pkg::KIND_VERDICT, 18'd0, 16'd0, fiv_pkg::ST_SHORT, 32'h0);
                    ph = fiv_pkg::PH_DONE;
                end
            end
            else if (h_magic != magic_reg)
            begin
                emit(fiv_pkg::KIND_VERDICT, 18'd0, 16'd0, fiv_pkg::ST_BAD_MAGIC, h_version);
                ph = fiv_pkg::PH_DONE;
            end
            else if (h_length == 32'h0 || h_length > effective_limit())
            begin
                emit(fiv_pkg::KIND_VERDICT, 18'd0, 16'd0, fiv_pkg::ST_BAD_LENGTH, h_version);
                ph = fiv_pkg::PH_DONE;
            end
            else if (eof)
            begin
                emit(fiv_pkg::KIND_VERDICT, 18'd0, 16'd0, fiv_pkg::ST_SHORT, h_version);
                ph = fiv_pkg::PH_DONE;
            end
            else
            begin
                ph  = fiv_pkg::PH_DATA;
                cnt = 19'd0;
            end
        end
        else if (ph == fiv_pkg::PH_DATA)
        begin
            // crc, halfword pairing, odd byte padding
            crc_acc    = crc32_step(crc_acc, b);
            final_byte = ({13'd0, cnt} + 32'd1) >= h_length;
            if (cnt[0])
            begin
                emit(fiv_pkg::KIND_WRITE, cnt[17:0] - 18'd1, {b, pend}, fiv_pkg::ST_OK, 32'h0);
            end
            else
            begin
                pend = b;
                if (final_byte || eof)
                begin
                    emit(fiv_pkg::KIND_WRITE, cnt[17:0], {fiv_pkg::PAD_BYTE, b},
                         fiv_pkg::ST_OK, 32'h0);
                end
            end
            cnt = cnt + 19'd1;
            if (final_byte)
            begin
                emit(fiv_pkg::KIND_VERDICT, 18'd0, 16'd0,
                     ((crc_acc ^ fiv_pkg::ALL_ONES) == h_crc)
                     ? fiv_pkg::ST_OK : fiv_pkg::ST_CRC_FAIL, h_version);
                ph = fiv_pkg::PH_DONE;
            end
            else if (eof)
            begin
                emit(fiv_pkg::KIND_VERDICT, 18'd0, 16'd0, fiv_pkg::ST_SHORT, h_version);
                ph = fiv_pkg::PH_DONE;
            end
        end
        if (step_n > 0)
        begin
            step_ops[step_n - 1].last = 1'b1;
        end
    endfunction

    // present one item after a random gap and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic sop, input logic eof);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        start_of_image <= sop;
        end_of_file    <= eof;
        do @(posedge clk); while (in_ready !== 1'b1);
    endtask

    // send one item and queue what the parser copy says it yields
    task automatic feed_byte(input logic [7:0] b, input logic sop, input logic eof);
        send_byte(b, sop, eof);
        if (ph != fiv_pkg::PH_DONE || sop)
        begin
            items_done++;
        end
        parse_image_byte(b, sop, eof);
        for (int i = 0; i < step_n; i++)
        begin
            flash_ops_due.push_back(step_ops[i]);
        end
    endtask

    // hold the input side until every result has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (flash_ops_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        if (idx == fiv_pkg::CFG_LENGTH_LIMIT)
        begin
            lim_reg = val[18:0];
        end
        else
        begin
            magic_reg = val;
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one image file: well formed with random content, or with one flaw, or plain noise
    task automatic send_image();
        flaw_t       flaw;
        logic [31:0] lim;
        logic [31:0] words [0:3];
        logic [31:0] crc;
        logic [7:0]  body [$];
        logic [7:0]  b;
        int          r;
        int          cap;
        int          len;
        int          eof_at;
        lim    = effective_limit();
        r      = $urandom_range(0, 11);
        flaw   = (r < 5) ? FLAW_NONE : (r >= 10) ? FLAW_NOISE : flaw_t'(r - 4);
        burst  = ($urandom_range(0, 9) == 0);
        eof_at = -1;

        if (flaw == FLAW_NOISE)
        begin
            repeat ($urandom_range(1, 12))
            begin
                feed_byte(8'($urandom()), $urandom_range(0, 3) == 0,
                          $urandom_range(0, 5) == 0);
            end
            return;
        end

        // body sized small, sometimes exactly at a small limit
        cap = (lim == 32'h0 || lim > 32'd24) ? 24 : int'(lim);
        len = $urandom_range(1, cap);
        if (lim != 32'h0 && lim <= 32'd64 && $urandom_range(0, 3) == 0)
        begin
            len = int'(lim);
        end
        crc = fiv_pkg::ALL_ONES;
        for (int i = 0; i < len; i++)
        begin
            body.push_back(8'($urandom()));
            crc = crc32_step(crc, body[i]);
        end
        words[0] = magic_reg;
        words[1] = $urandom();
        words[2] = 32'(len);
        words[3] = crc ^ fiv_pkg::ALL_ONES;

        case (flaw)
            FLAW_MAGIC:
            begin
                words[0] = $urandom();
                if (words[0] == magic_reg)
                begin
                    words[0] = ~words[0];
                end
            end
            FLAW_LENGTH:
            begin
                case ($urandom_range(0, 3))
                    0:       words[2] = 32'h0;
                    1:       words[2] = lim + 32'd1;
                    2:       words[2] = fiv_pkg::ALL_ONES;
                    default: words[2] = lim + 32'd1 + 32'($urandom_range(0, 1000));
                endcase
            end
            FLAW_EOF_HDR:  eof_at = $urandom_range(0, 15);
            FLAW_EOF_DATA: eof_at = 16 + $urandom_range(0, len - 1);
            FLAW_CRC:      words[3] = words[3] ^ (32'h1 << $urandom_range(0, 31));
            default:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    eof_at = 15 + len;
                end
            end
        endcase

        for (int i = 0; i < 16 + len; i++)
        begin
            b = (i < 16) ? words[i / 4][8 * (i % 4) +: 8] : body[i - 16];
            feed_byte(b, i == 0, i == eof_at);
            if (ph == fiv_pkg::PH_DONE)
            begin
                break;
            end
        end

        // stray bytes after the verdict are dropped
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                feed_byte(8'($urandom()), 1'b0, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // output side: random stalls and in-order comparison
    initial
    begin : result_check
        flash_op_t got;
        flash_op_t want;
        logic      took;
        int        stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            took = (out_valid === 1'b1) && out_ready;
            got  = '{kind, write_offset, halfword, status, image_version, last};
            if (took)
            begin
                stall = draw_gap();
            end
            else if (stall > 0)
            begin
                stall--;
            end
            out_ready <= (stall == 0);
            // let the input side queue this edge's prediction first
            #1;
            if (took)
            begin
                if (flash_ops_due.size() == 0)
                begin
                    $error("unexpected result: kind %0h offset %0h halfword %0h status %0h",
                           got.kind, got.write_offset, got.halfword, got.status);
                    errors++;
                end
                else
                begin
                    want = flash_ops_due.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $error("kind: expected %0h, got %0h", want.kind, got.kind);
                        errors++;
                    end
                    if (got.write_offset !== want.write_offset)
                    begin
                        $error("write_offset: expected %0h, got %0h",
                               want.write_offset, got.write_offset);
                        errors++;
                    end
                    if (got.halfword !== want.halfword)
                    begin
                        $error("halfword: expected %0h, got %0h", want.halfword, got.halfword);
                        errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0h, got %0h", want.status, got.status);
                        errors++;
                    end
                    if (got.image_version !== want.image_version)
                    begin
                        $error("image_version: expected %0h, got %0h",
                               want.image_version, got.image_version);
                        errors++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0h, got %0h", want.last, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    // reset, directed table, then random phases over several register settings
    initial
    begin : stimulus
        logic [18:0] lim;
        logic [31:0] mag;
        flash_op_t   pinned_op;
        lim_reg   = fiv_pkg::LIMIT_RESET;
        magic_reg = fiv_pkg::MAGIC_RESET;
        clear_parse();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
        begin
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].sop, DIRECTED_ROWS[i].eof);
            parse_image_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].sop,
                             DIRECTED_ROWS[i].eof);
            if (DIRECTED_ROWS[i].pinned)
            begin
                pinned_op = '{fiv_pkg::KIND_VERDICT, 18'd0, 16'd0, DIRECTED_ROWS[i].status,
                              DIRECTED_ROWS[i].version, 1'b1};
                flash_ops_due.push_back(pinned_op);
            end
            else
            begin
                for (int j = 0; j < step_n; j++)
                begin
                    flash_ops_due.push_back(step_ops[j]);
                end
            end
        end

        items_done = 0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            if (p > 0)
            begin
                case (p)
                    1:
                    begin
                        lim = 19'h7FFFF;
                        mag = 32'h0000_0000;
                    end
                    2:
                    begin
                        lim = 19'd1;
                        mag = 32'hFFFF_FFFF;
                    end
                    3:
                    begin
                        lim = 19'd0;
                        mag = $urandom();
                    end
                    4:
                    begin
                        lim = 19'($urandom_range(2, 64));
                        mag = fiv_pkg::MAGIC_RESET;
                    end
                    default:
                    begin
                        lim = fiv_pkg::LIMIT_RESET;
                        mag = $urandom();
                    end
                endcase
                // upper data bits beyond the limit field are random
                write_reg(fiv_pkg::CFG_LENGTH_LIMIT, {13'($urandom()), lim});
                write_reg(fiv_pkg::CFG_EXPECTED_MAGIC, mag);
            end
            while (items_done < (p + 1) * ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    wait_drained();
                end
                send_image();
            end
        end

        wait_drained();
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fiv_pkg.sv
rtl/core/fiv_front.sv
rtl/core/fiv_queue.sv
rtl/core/fiv_back.sv
rtl/core/firmware_image_verifier_unit.sv
dv/firmware_image_verifier_unit_test.sv
